FILE: hdl/dense_shortest_path_solver_assert.svh
// assertion macros used by the checker file
`ifndef DENSE_SHORTEST_PATH_SOLVER_ASSERT_SVH
`define DENSE_SHORTEST_PATH_SOLVER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dsp_pkg.sv
// shared types and constants of the shortest path solver
package dsp_pkg;

    localparam int DSP_MAX_VERTICES = 63;
    localparam int DSP_WEIGHT_BITS  = 16;
    localparam int DSP_DIST_BITS    = 32;

    localparam int VERTEX_W = 6;
    localparam int WEIGHT_W = 16;
    localparam int PATH_W   = 32;

    localparam logic [1:0] CMD_SET_EDGE = 2'd0;
    localparam logic [1:0] CMD_SOLVE    = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic [WEIGHT_W-1:0] weight;
        logic [VERTEX_W-1:0] vertex;
    } dsp_request_t;

    typedef struct packed {
        logic              status;
        logic [PATH_W-1:0] path_length;
        logic              reached;
    } dsp_result_t;

endpackage

FILE: hdl/dense_shortest_path_solver.sv
// top level of the dense shortest path solver
//
//  channel   signals                 handshake
//  command   start, request          taken when start is high and busy is low
//  result    done, result            done high for one cycle, no back-pressure
//
// after reset a clearing pass writes all 2**(2*VW) adjacency entries
// (4096 at 63 vertices), with busy high
// set edge and rejected commands: result in the next cycle, next item at once
// query: one distance memory read; the read data is registered, then ST_QUERY
// registers the result. solve over n vertices: an init pass over the distances, then
// per round a scan for the nearest unvisited vertex, a mark step and, if it is reachable, a relax pass
module dense_shortest_path_solver import dsp_pkg::*; #(
    parameter int MAX_VERTICES = DSP_MAX_VERTICES,
    parameter int WEIGHT_BITS  = DSP_WEIGHT_BITS,
    parameter int DIST_BITS    = DSP_DIST_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  dsp_request_t request,
    output logic         busy,
    output logic         done,
    output dsp_result_t  result
);

    localparam int NV = MAX_VERTICES + 1;
    localparam int VW = $clog2(NV);
    localparam int AW = 2 * VW;
    localparam int CW = (VW > VERTEX_W) ? VW : VERTEX_W;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
    localparam logic [CW-1:0]        MAX_V    = CW'(MAX_VERTICES);
    localparam logic [VW-1:0]        ONE_V    = VW'(1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_QUERY = 3'd2;
    localparam logic [2:0] ST_INIT  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_MARK  = 3'd5;
    localparam logic [2:0] ST_RELAX = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [VW-1:0]        count_reg, count_next;
    logic [VW-1:0]        src_reg, src_next;
    logic [VW-1:0]        idx_reg, idx_next;
    logic [VW-1:0]        round_reg, round_next;
    logic [VW-1:0]        pick_reg, pick_next;
    logic [DIST_BITS-1:0] best_reg, best_next;
    logic                 found_reg, found_next;
    logic                 issued_reg, issued_next;
    logic                 pend_reg, pend_next;
    logic [VW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 done_reg, done_next;
    dsp_result_t          result_reg, result_next;

    logic                   edge_we;
    logic [AW-1:0]          edge_waddr;
    logic [WEIGHT_BITS-1:0] edge_wdata;
    logic [AW-1:0]          edge_raddr;
    logic [WEIGHT_BITS-1:0] edge_rdata;

    logic                 dist_we;
    logic [VW-1:0]        dist_waddr;
    logic                 dist_wdone;
    logic [DIST_BITS-1:0] dist_wdist;
    logic [VW-1:0]        dist_raddr;
    logic                 dist_rdone;
    logic [DIST_BITS-1:0] dist_rdist;

    logic                 relax_upd;
    logic [DIST_BITS-1:0] relax_sum;

    logic [CW-1:0] fv_c, tv_c, v_c, count_c;
    logic          fv_bad, tv_bad, v_bad;
    logic [VW-1:0] fv_idx, tv_idx, v_idx;
    logic [VW-1:0] cnt_a, cnt_b;
    logic          advance;
    logic          finish;
    logic          reject;

    dsp_edge_ram #(
        .ADDR_W (AW),
        .DATA_W (WEIGHT_BITS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dsp_dist_store #(
        .NV (NV),
        .VW (VW),
        .DB (DIST_BITS)
    ) u_dist_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdone (dist_wdone),
        .wdist (dist_wdist),
        .raddr (dist_raddr),
        .rdone (dist_rdone),
        .rdist (dist_rdist)
    );

    dsp_relax #(
        .WB (WEIGHT_BITS),
        .DB (DIST_BITS)
    ) u_relax (
        .base   (best_reg),
        .weight (edge_rdata),
        .cur    (dist_rdist),
        .upd    (relax_upd),
        .sum    (relax_sum)
    );

    // range checks on the item's vertex fields
    assign fv_c    = CW'(request.from_vertex);
    assign tv_c    = CW'(request.to_vertex);
    assign v_c     = CW'(request.vertex);
    assign count_c = CW'(count_reg);
    assign fv_bad  = (fv_c == '0) || (fv_c > MAX_V);
    assign tv_bad  = (tv_c == '0) || (tv_c > MAX_V);
    assign v_bad   = (v_c == '0) || (v_c > count_c);
    assign fv_idx  = VW'(request.from_vertex);
    assign tv_idx  = VW'(request.to_vertex);
    assign v_idx   = VW'(request.vertex);
    assign cnt_a   = (fv_idx > count_reg) ? fv_idx : count_reg;
    assign cnt_b   = (tv_idx > cnt_a) ? tv_idx : cnt_a;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        src_next      = src_reg;
        idx_next      = idx_reg;
        round_next    = round_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        issued_next   = issued_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        edge_we    = 1'b0;
        edge_waddr = {fv_idx, tv_idx};
        edge_wdata = WEIGHT_BITS'(request.weight);
        edge_raddr = {pick_reg, idx_reg};

        dist_we    = 1'b0;
        dist_waddr = idx_reg;
        dist_wdone = 1'b0;
        dist_wdist = DIST_INF;
        dist_raddr = idx_reg;

        advance = 1'b0;
        finish  = 1'b0;
        reject  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_waddr = clr_reg;
                edge_wdata = '0;
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    case (request.cmd)
                        CMD_SET_EDGE:
                        begin
                            if (fv_bad || tv_bad)
                            begin
                                reject = 1'b1;
                            end
                            else
                            begin
                                edge_we                 = 1'b1;
                                count_next              = cnt_b;
                                done_next               = 1'b1;
                                result_next.status      = STATUS_OK;
                                result_next.path_length = '0;
                                result_next.reached     = 1'b0;
                            end
                        end
                        CMD_SOLVE:
                        begin
                            if (v_bad)
                            begin
                                reject = 1'b1;
                            end
                            else
                            begin
                                src_next   = v_idx;
                                idx_next   = ONE_V;
                                state_next = ST_INIT;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (v_bad)
                            begin
                                reject = 1'b1;
                            end
                            else
                            begin
                                dist_raddr = v_idx;
                                state_next = ST_QUERY;
                            end
                        end
                        default:
                        begin
                            reject = 1'b1;
                        end
                    endcase
                end
            end

            ST_QUERY:
            begin
                done_next               = 1'b1;
                result_next.status      = STATUS_OK;
                result_next.path_length = PATH_W'(dist_rdist);
                result_next.reached     = (dist_rdist != DIST_INF);
                state_next              = ST_IDLE;
            end

            ST_INIT:
            begin
                dist_we    = 1'b1;
                dist_wdone = 1'b0;
                dist_wdist = (idx_reg == src_reg) ? '0 : DIST_INF;
                if (idx_reg == count_reg)
                begin
                    idx_next    = ONE_V;
                    round_next  = ONE_V;
                    found_next  = 1'b0;
                    issued_next = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + ONE_V;
                end
            end

            ST_SCAN:
            begin
                if (!issued_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    if (idx_reg == count_reg)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE_V;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // lowest distance among unvisited, strict compare keeps lowest index
                if (pend_reg)
                begin
                    if (!dist_rdone && (!found_reg || (dist_rdist < best_reg)))
                    begin
                        pick_next  = pend_idx_reg;
                        best_next  = dist_rdist;
                        found_next = 1'b1;
                    end
                    if (pend_idx_reg == count_reg)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end

            ST_MARK:
            begin
                if (!found_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    dist_we    = 1'b1;
                    dist_waddr = pick_reg;
                    dist_wdone = 1'b1;
                    dist_wdist = best_reg;
                    if (best_reg == DIST_INF)
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        idx_next    = ONE_V;
                        issued_next = 1'b0;
                        pend_next   = 1'b0;
                        state_next  = ST_RELAX;
                    end
                end
            end

            ST_RELAX:
            begin
                if (!issued_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    if (idx_reg == count_reg)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE_V;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // write-back trails the read by one entry, so no overlap
                if (pend_reg)
                begin
                    if (relax_upd)
                    begin
                        dist_we    = 1'b1;
                        dist_waddr = pend_idx_reg;
                        dist_wdone = dist_rdone;
                        dist_wdist = relax_sum;
                    end
                    if (pend_idx_reg == count_reg)
                    begin
                        advance = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (round_reg == count_reg)
            begin
                finish = 1'b1;
            end
            else
            begin
                round_next  = round_reg + ONE_V;
                idx_next    = ONE_V;
                found_next  = 1'b0;
                issued_next = 1'b0;
                pend_next   = 1'b0;
                state_next  = ST_SCAN;
            end
        end

        if (finish)
        begin
            state_next              = ST_IDLE;
            done_next               = 1'b1;
            result_next.status      = STATUS_OK;
            result_next.path_length = '0;
            result_next.reached     = 1'b0;
        end

        if (reject)
        begin
            done_next               = 1'b1;
            result_next.status      = STATUS_REJECT;
            result_next.path_length = '0;
            result_next.reached     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            round_reg    <= '0;
            found_reg    <= 1'b0;
            issued_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            round_reg    <= round_next;
            found_reg    <= found_next;
            issued_reg   <= issued_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/dsp_edge_ram.sv
// adjacency matrix store: one write port, one registered read port
module dsp_edge_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] ram_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/dsp_dist_store.sv
// distance and done-flag store with per-entry valid bits for the reset value
module dsp_dist_store #(
    parameter int NV = 64,
    parameter int VW = 6,
    parameter int DB = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [VW-1:0] waddr,
    input  logic          wdone,
    input  logic [DB-1:0] wdist,
    input  logic [VW-1:0] raddr,
    output logic          rdone,
    output logic [DB-1:0] rdist
);

    logic [DB:0]   ram_reg [NV];
    logic [DB:0]   rword_reg;
    logic [NV-1:0] valid_reg;
    logic          rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= {wdone, wdist};
        end
        rword_reg <= ram_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // never-written entries read as not done and unreachable
    assign rdone = rvalid_reg ? rword_reg[DB] : 1'b0;
    assign rdist = rvalid_reg ? rword_reg[DB-1:0] : {DB{1'b1}};

endmodule

FILE: hdl/dsp_relax.sv
// edge relaxation: saturating distance plus weight, compared to the stored distance
module dsp_relax #(
    parameter int WB = 16,
    parameter int DB = 32
) (
    input  logic [DB-1:0] base,
    input  logic [WB-1:0] weight,
    input  logic [DB-1:0] cur,
    output logic          upd,
    output logic [DB-1:0] sum
);

    localparam int SW = ((DB > WB) ? DB : WB) + 1;
    localparam logic [SW-1:0] INF_W = SW'({DB{1'b1}});

    logic [SW-1:0] sum_full;
    logic          sat;

    assign sum_full = SW'(base) + SW'(weight);
    assign sat      = (sum_full >= INF_W);
    // saturate one below unreachable so the result stays finite
    assign sum      = sat ? {{(DB-1){1'b1}}, 1'b0} : sum_full[DB-1:0];
    assign upd      = (weight != '0) && (sum < cur);

endmodule

FILE: hdl/dsp_checker.sv
// port-level checker for the shortest path solver, bound to the top level
`include "dense_shortest_path_solver_assert.svh"

module dsp_checker import dsp_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input dsp_request_t request,
    input logic         busy,
    input logic         done,
    input dsp_result_t  result
);

    `DSP_ASSERT_SAME(a_reject_clean, done && (result.status == STATUS_REJECT), (result.path_length == '0) && !result.reached, "rejected item carries a distance")

    `DSP_ASSERT_NEXT(a_zero_endpoint, start && !busy && (request.cmd == CMD_SET_EDGE) && ((request.from_vertex == '0) || (request.to_vertex == '0)), done && (result.status == STATUS_REJECT), "edge with vertex zero not rejected at once")

    `DSP_ASSERT_NEXT(a_bad_cmd, start && !busy && (request.cmd != CMD_SET_EDGE) && (request.cmd != CMD_SOLVE) && (request.cmd != CMD_QUERY), done && (result.status == STATUS_REJECT), "unknown command not rejected at once")

    `DSP_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")

endmodule

bind dense_shortest_path_solver dsp_checker u_checker (.*);

FILE: test/tb_dense_shortest_path_solver.sv
`timescale 1ns / 1ps
// testbench of the dense shortest path solver: directed table, then random graphs vs a model
module tb_dense_shortest_path_solver;
    import dsp_pkg::*;

    localparam int NV = DSP_MAX_VERTICES + 1;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [DSP_DIST_BITS-1:0] UNREACHED = '1;
    // longest quiet stretch is a solve over 63 vertices
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int TAIL_CYCLES = 20;
    localparam int EARLY_ITEMS = 105;
    localparam int EARLY_SPAN = 9;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        dsp_request_t req;
        bit           typed;
        dsp_result_t  want;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    dsp_request_t request;
    logic         busy;
    logic         done;
    dsp_result_t  result;

    // model state
    logic [DSP_WEIGHT_BITS-1:0] edge_len [0:NV-1][0:NV-1];
    logic [DSP_DIST_BITS-1:0]   path_dist [0:NV-1];
    bit                         settled [0:NV-1];
    int unsigned                live_vertices;

    dsp_result_t pending_q [$];
    stim_row_t   directed_rows [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int n_sent = 0;
    int n_edges = 0;
    int n_solves = 0;
    int n_queries = 0;
    int n_rejects = 0;
    int n_reached = 0;
    bit gaps_on = 1'b0;

    dense_shortest_path_solver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_graph();
        int unsigned i;
        int unsigned j;
        for (i = 0; i < NV; i++)
        begin
            for (j = 0; j < NV; j++)
                edge_len[i][j] = '0;
            path_dist[i] = UNREACHED;
            settled[i] = 1'b0;
        end
        live_vertices = 0;
    endfunction

    function automatic void solve_from(int unsigned src);
        int unsigned i;
        int unsigned rnd;
        int unsigned pick;
        logic [DSP_DIST_BITS:0] sum;
        for (i = 1; i <= live_vertices; i++)
        begin
            path_dist[i] = UNREACHED;
            settled[i] = 1'b0;
        end
        path_dist[src] = '0;
        for (rnd = 1; rnd <= live_vertices; rnd++)
        begin
            pick = 0;
            // lowest index wins ties
            for (i = 1; i <= live_vertices; i++)
                if (!settled[i] && (pick == 0 || path_dist[i] < path_dist[pick]))
                    pick = i;
            if (pick == 0)
                break;
            settled[pick] = 1'b1;
            // an unreachable pick is marked but relaxes nothing
            if (path_dist[pick] != UNREACHED)
            begin
                for (i = 1; i <= live_vertices; i++)
                begin
                    if (edge_len[pick][i] != 0)
                    begin
                        sum = {1'b0, path_dist[pick]} +
                              (DSP_DIST_BITS+1)'(edge_len[pick][i]);
                        if (sum >= {1'b0, UNREACHED})
                            sum = {1'b0, UNREACHED - 1'b1};
                        if (sum[DSP_DIST_BITS-1:0] < path_dist[i])
                            path_dist[i] = sum[DSP_DIST_BITS-1:0];
                    end
                end
            end
        end
    endfunction

    function automatic dsp_result_t shortest_path_model(dsp_request_t r);
        dsp_result_t res;
        res = '0;
        res.status = STATUS_OK;
        case (r.cmd)
            CMD_SET_EDGE:
            begin
                if (r.from_vertex == 0 || r.to_vertex == 0 ||
                    r.from_vertex > DSP_MAX_VERTICES || r.to_vertex > DSP_MAX_VERTICES)
                    res.status = STATUS_REJECT;
                else
                begin
                    edge_len[r.from_vertex][r.to_vertex] = r.weight;
                    if (r.from_vertex > live_vertices)
                        live_vertices = 32'(r.from_vertex);
                    if (r.to_vertex > live_vertices)
                        live_vertices = 32'(r.to_vertex);
                end
            end
            CMD_SOLVE:
            begin
                if (r.vertex == 0 || r.vertex > live_vertices)
                    res.status = STATUS_REJECT;
                else
                    solve_from(r.vertex);
            end
            CMD_QUERY:
            begin
                if (r.vertex == 0 || r.vertex > live_vertices)
                    res.status = STATUS_REJECT;
                else
                begin
                    res.path_length = path_dist[r.vertex];
                    res.reached = (path_dist[r.vertex] != UNREACHED);
                end
            end
            default:
                res.status = STATUS_REJECT;
        endcase
        return res;
    endfunction

    function automatic dsp_request_t make_request(logic [1:0] c, int fv, int tv, int w, int v);
        dsp_request_t r;
        r.cmd = c;
        r.from_vertex = VERTEX_W'(fv);
        r.to_vertex = VERTEX_W'(tv);
        r.weight = WEIGHT_W'(w);
        r.vertex = VERTEX_W'(v);
        return r;
    endfunction

    function automatic dsp_result_t make_result(logic st, logic [PATH_W-1:0] pl, logic rc);
        dsp_result_t res;
        res.status = st;
        res.path_length = pl;
        res.reached = rc;
        return res;
    endfunction

    function automatic dsp_request_t random_request();
        return make_request(2'($urandom_range(0, 2)), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 65535),
                            $urandom_range(0, 63));
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return WEIGHT_W'($urandom_range(1, 20));
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int random_endpoint(int span);
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, span);
    endfunction

    task automatic add_row(dsp_request_t r, bit typed, dsp_result_t want);
        stim_row_t row;
        row.req = r;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(dsp_request_t r, bit typed, dsp_result_t typed_want);
        dsp_result_t want;
        int hold;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            hold = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = shortest_path_model(r);
        n_sent++;
        case (r.cmd)
            CMD_SET_EDGE: n_edges++;
            CMD_SOLVE: n_solves++;
            CMD_QUERY: n_queries++;
            default: ;
        endcase
        if (want.status == STATUS_REJECT)
            n_rejects++;
        if (want.reached)
            n_reached++;
        pending_q.push_back(typed ? typed_want : want);
    endtask

    task automatic send_edge(int span);
        dsp_request_t r;
        r = random_request();
        r.cmd = CMD_SET_EDGE;
        r.from_vertex = VERTEX_W'(random_endpoint(span));
        r.to_vertex = VERTEX_W'(random_endpoint(span));
        r.weight = random_weight();
        send_item(r, 1'b0, '0);
    endtask

    task automatic send_on_vertex(logic [1:0] c, int v);
        dsp_request_t r;
        r = random_request();
        r.cmd = c;
        r.vertex = VERTEX_W'(v);
        send_item(r, 1'b0, '0);
    endtask

    // hold the sender off until every outstanding result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        dsp_result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (pending_q.size() == 0)
                    report("result with nothing pending, path_length", 0, result.path_length);
                else
                begin
                    want = pending_q.pop_front();
                    if (result.status !== want.status)
                        report("status", want.status, result.status);
                    if (result.path_length !== want.path_length)
                        report("path_length", want.path_length, result.path_length);
                    if (result.reached !== want.reached)
                        report("reached", want.reached, result.reached);
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        dsp_result_t rejected;
        dsp_result_t accepted;
        int batch;
        int k;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        clear_graph();
        rejected = make_result(STATUS_REJECT, '0, 1'b0);
        accepted = make_result(STATUS_OK, '0, 1'b0);

        // empty graph, unknown command, bad endpoints
        add_row(make_request(CMD_QUERY, 0, 0, 0, 1), 1'b1, rejected);
        add_row(make_request(CMD_SOLVE, 0, 0, 0, 1), 1'b1, rejected);
        add_row(make_request(CMD_UNUSED, 63, 63, 16'hFFFF, 63), 1'b1, rejected);
        add_row(make_request(CMD_SET_EDGE, 0, 1, 5, 0), 1'b1, rejected);
        add_row(make_request(CMD_SET_EDGE, 1, 0, 5, 0), 1'b1, rejected);
        // small graph with a tie between vertices 2 and 3
        add_row(make_request(CMD_SET_EDGE, 1, 2, 16'hFFFF, 0), 1'b1, accepted);
        add_row(make_request(CMD_SET_EDGE, 2, 3, 1, 0), 1'b1, accepted);
        add_row(make_request(CMD_SET_EDGE, 1, 3, 16'hFFFF, 0), 1'b1, accepted);
        // zero weight still grows the vertex count to 4
        add_row(make_request(CMD_SET_EDGE, 3, 4, 0, 0), 1'b1, accepted);
        add_row(make_request(CMD_SET_EDGE, 4, 1, 7, 0), 1'b1, accepted);
        add_row(make_request(CMD_QUERY, 0, 0, 0, 4), 1'b1,
                make_result(STATUS_OK, UNREACHED, 1'b0));
        add_row(make_request(CMD_QUERY, 0, 0, 0, 5), 1'b1, rejected);
        add_row(make_request(CMD_SOLVE, 0, 0, 0, 5), 1'b1, rejected);
        add_row(make_request(CMD_SOLVE, 0, 0, 0, 0), 1'b1, rejected);
        add_row(make_request(CMD_QUERY, 0, 0, 0, 0), 1'b1, rejected);
        add_row(make_request(CMD_SOLVE, 0, 0, 0, 1), 1'b0, '0);
        for (k = 1; k <= 4; k++)
            add_row(make_request(CMD_QUERY, 0, 0, 0, k), 1'b0, '0);
        // remove an existing edge, add a detour, solve again
        add_row(make_request(CMD_SET_EDGE, 1, 3, 0, 0), 1'b0, '0);
        add_row(make_request(CMD_SET_EDGE, 2, 4, 3, 0), 1'b0, '0);
        add_row(make_request(CMD_SOLVE, 0, 0, 0, 1), 1'b0, '0);
        add_row(make_request(CMD_QUERY, 0, 0, 0, 3), 1'b0, '0);
        add_row(make_request(CMD_QUERY, 0, 0, 0, 4), 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // random graphs on few vertices keep solves short
        batch = 0;
        while (n_sent < EARLY_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(1, 6);
            repeat (n) send_edge(EARLY_SPAN);
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(make_request(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 65535), $urandom_range(0, 63)),
                          1'b0, '0);
            end
            if ($urandom_range(0, 7) == 0)
                send_on_vertex(CMD_SOLVE, ($urandom_range(0, 1) == 0) ? 0 :
                               live_vertices + $urandom_range(1, 3));
            else
                send_on_vertex(CMD_SOLVE, $urandom_range(1, live_vertices));
            n = $urandom_range(2, 5);
            repeat (n) send_on_vertex(CMD_QUERY, $urandom_range(0, live_vertices + 2));
            if (batch == 0 || $urandom_range(0, 3) == 0)
                drain();
            batch++;
        end

        // full-size graph, steady stream
        gaps_on = 1'b0;
        send_item(make_request(CMD_SET_EDGE, 1, DSP_MAX_VERTICES, 16'hFFFF, 0), 1'b0, '0);
        send_item(make_request(CMD_SET_EDGE, DSP_MAX_VERTICES, 2, 1, 0), 1'b0, '0);
        repeat (14) send_edge(DSP_MAX_VERTICES);
        send_on_vertex(CMD_SOLVE, 1);
        repeat (10) send_on_vertex(CMD_QUERY, $urandom_range(0, 63));
        send_on_vertex(CMD_SOLVE, DSP_MAX_VERTICES);
        repeat (6) send_on_vertex(CMD_QUERY, $urandom_range(0, 63));

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_q.size() != 0)
            report("results still pending, count", 0, pending_q.size());

        $display("covered %0d items: %0d edge writes, %0d solves, %0d queries, %0d rejected",
                 n_sent, n_edges, n_solves, n_queries, n_rejects);
        $display("%0d queries found a finite path, final vertex count %0d",
                 n_reached, live_vertices);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
